// File: sv/onewire_rom_search_engine_defines.svh
// ----------------------------------------------------------------------------
// onewire_rom_search_engine assertion macros
// shared property wrappers for the rom search engine checkers
// ----------------------------------------------------------------------------
`ifndef ONEWIRE_ROM_SEARCH_ENGINE_DEFINES_SVH
`define ONEWIRE_ROM_SEARCH_ENGINE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define ORS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define ORS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/ors_pkg.sv
// ----------------------------------------------------------------------------
// ors_pkg
// types and constants of the 1-wire rom search engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ors_pkg;

  // item codes carried on the input tuser
  typedef enum logic [1:0] {
    FUNC_BEGIN = 2'd0,
    FUNC_PAIR  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_e;

  localparam logic [7:0] CRC_POLY_REFL     = 8'h8C;
  localparam logic [6:0] LAST_BIT_PLUS_ONE = 7'd65;
  localparam logic [6:0] FAMILY_LIMIT      = 7'd9;
  localparam logic [6:0] FIRST_BIT         = 7'd1;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 80;

  // one registered input item
  typedef struct packed {
    logic [1:0] func;
    logic       presence;
    logic       id_bit;
    logic       cmp_bit;
  } item_t;

  // one result item
  typedef struct packed {
    logic [3:0]  family_discrepancy;
    logic [63:0] rom_code;
    logic        found;
    logic        done_res;
    logic        write_bit;
    logic        write_valid;
    logic        send_search_cmd;
  } result_t;

  // search state kept between items
  typedef struct packed {
    logic [63:0] rom_bits;
    logic [6:0]  bit_number;
    logic [6:0]  last_zero_pos;
    logic [6:0]  last_discrepancy;
    logic [3:0]  family_disc;
    logic        last_device;
    logic [7:0]  crc_acc;
    logic        searching;
  } state_t;

endpackage

// File: sv/ors_core.sv
// ----------------------------------------------------------------------------
// ors_core
// search state registers and the per-item decision logic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ors_core
  import ors_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    advance_i,
  input  item_t   item_i,
  output result_t result_o
);

  state_t      state_q, state_d;
  result_t     res;
  func_e       func;
  logic [5:0]  pos;
  logic        rom_bit_sel;
  logic        dir;
  logic        forced;
  logic [63:0] rom_next;
  logic [7:0]  crc_next;
  logic [6:0]  bn_next;
  logic        found_tmp;

  assign func = func_e'(item_i.func);

  // bit position and direction choice for a bit pair
  assign pos         = state_q.bit_number[5:0] - 6'd1;
  assign rom_bit_sel = state_q.rom_bits[pos];
  assign forced      = item_i.id_bit != item_i.cmp_bit;

  always_comb begin
    if (forced) begin
      dir = item_i.id_bit;
    end else if (state_q.bit_number < state_q.last_discrepancy) begin
      dir = rom_bit_sel;
    end else begin
      dir = state_q.bit_number == state_q.last_discrepancy;
    end
  end

  // rom code, crc and bit counter after a written bit
  always_comb begin
    rom_next      = state_q.rom_bits;
    rom_next[pos] = dir;
  end

  assign crc_next = (state_q.crc_acc[0] ^ dir) ? ((state_q.crc_acc >> 1) ^ CRC_POLY_REFL)
                                               : (state_q.crc_acc >> 1);
  assign bn_next  = state_q.bit_number + 7'd1;

  // next state and result
  always_comb begin
    state_d   = state_q;
    res       = '0;
    found_tmp = 1'b0;
    unique case (func)
      FUNC_BEGIN: begin
        state_d.searching = 1'b0;
        if (state_q.last_device || !item_i.presence) begin
          state_d.last_discrepancy = '0;
          state_d.last_device      = 1'b0;
          state_d.family_disc      = '0;
          res.done_res             = 1'b1;
        end else begin
          res.send_search_cmd   = 1'b1;
          state_d.searching     = 1'b1;
          state_d.bit_number    = FIRST_BIT;
          state_d.last_zero_pos = '0;
          state_d.crc_acc       = '0;
        end
      end
      FUNC_PAIR: begin
        if (state_q.searching) begin
          if (item_i.id_bit && item_i.cmp_bit) begin
            // no device answered
            state_d.searching = 1'b0;
            res.done_res      = 1'b1;
          end else begin
            state_d.rom_bits = rom_next;
            if (!forced && !dir) begin
              state_d.last_zero_pos = state_q.bit_number;
              if (state_q.bit_number < FAMILY_LIMIT) begin
                state_d.family_disc = state_q.bit_number[3:0];
              end
            end
            res.write_valid    = 1'b1;
            res.write_bit      = dir;
            state_d.crc_acc    = crc_next;
            state_d.bit_number = bn_next;
            // end of the pass after the last rom bit
            if (bn_next >= LAST_BIT_PLUS_ONE) begin
              state_d.searching = 1'b0;
              res.done_res      = 1'b1;
              if (crc_next == 8'd0) begin
                state_d.last_discrepancy = state_d.last_zero_pos;
                if (state_d.last_zero_pos == 7'd0) begin
                  state_d.last_device = 1'b1;
                end
                found_tmp = 1'b1;
              end
              if (!found_tmp || rom_next[7:0] == 8'd0) begin
                state_d.last_discrepancy = '0;
                state_d.last_device      = 1'b0;
                state_d.family_disc      = '0;
                found_tmp                = 1'b0;
              end
            end
          end
        end
      end
      FUNC_CLEAR: begin
        state_d.last_discrepancy = '0;
        state_d.last_device      = 1'b0;
        state_d.family_disc      = '0;
        state_d.searching        = 1'b0;
      end
      default: begin
        state_d = state_q;
      end
    endcase
    res.found              = found_tmp;
    res.rom_code           = state_d.rom_bits;
    res.family_discrepancy = state_d.family_disc;
  end

  assign result_o = res;

  // state update on each processed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{bit_number: FIRST_BIT, default: '0};
    end else if (advance_i) begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/onewire_rom_search_engine.sv
// One item per clock cycle, sustained while the output side does not stall:
// an accepted item is held in the input register, the decision logic
// handles it there and the result is loaded into the output register when
// the item moves on. Between those two registers lies a single step
// (one rom bit select, a compare against the last discrepancy and a one-bit
// crc update). A waiting result does not stop the next item from being
// taken into the input register; stalls on the output side back up through
// both registers.
// ----------------------------------------------------------------------------
// onewire_rom_search_engine
// 1-wire search rom decision engine with stream ports
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module onewire_rom_search_engine
  import ors_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [0] presence, [1] id_bit, [2] cmp_bit, [7:3] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [1:0] func
  input  logic [1:0]             s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [0] send_search_cmd, [1] write_valid, [2] write_bit, [3] done_res,
  // [4] found, [68:5] rom_code, [72:69] family_discrepancy, [79:73] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  logic    in_valid_q;
  item_t   in_item_q;
  logic    out_valid_q;
  result_t out_q;
  result_t step_res;
  logic    advance;
  logic    in_xfer;

  // item moves from the input register into the result register
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_item_q.func     <= s_axis_tuser_i;
      in_item_q.presence <= s_axis_tdata_i[0];
      in_item_q.id_bit   <= s_axis_tdata_i[1];
      in_item_q.cmp_bit  <= s_axis_tdata_i[2];
    end
  end

  ors_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(advance),
    .item_i   (in_item_q),
    .result_o (step_res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= step_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_q};

endmodule

// File: sv/ors_checker.sv
// ----------------------------------------------------------------------------
// ors_checker
// port-level checks for the rom search engine, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "onewire_rom_search_engine_defines.svh"

module ors_checker
  import ors_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tready_o,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  // a stalled result holds
  `ORS_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o), "result changed under stall")

  // found only comes with the end of a pass
  `ORS_ASSERT_NOW(a_found_done, m_axis_tvalid_o && m_axis_tdata_o[4], m_axis_tdata_o[3], "found without done")

  // a direction bit of one only with a write
  `ORS_ASSERT_NOW(a_wbit_valid, m_axis_tvalid_o && m_axis_tdata_o[2], m_axis_tdata_o[1], "write bit without write")

  // the search command starts a pass and never ends or writes in the same result
  `ORS_ASSERT_NOW(a_cmd_alone, m_axis_tvalid_o && m_axis_tdata_o[0], !m_axis_tdata_o[1] && !m_axis_tdata_o[3], "search command mixed with write or done")

  // with no result waiting the input side is always open
  `ORS_ASSERT_NOW(a_ready_empty, !m_axis_tvalid_o, s_axis_tready_o, "input blocked with empty output")

endmodule

bind onewire_rom_search_engine ors_checker u_ors_checker (.*);
